// ===== rtl/llgsr_pkg.sv =====
// Shared constants for the lon/lat grid scatter resampler.
// Register codes, op and status codes, reset values, fixed-point constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package llgsr_pkg;

  // Default grid store dimensions
  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;

  // Configuration register indexes
  localparam logic [2:0] REG_MIN_LON     = 3'd0;
  localparam logic [2:0] REG_MIN_LAT     = 3'd1;
  localparam logic [2:0] REG_LON_SCALE   = 3'd2;
  localparam logic [2:0] REG_LAT_SCALE   = 3'd3;
  localparam logic [2:0] REG_GRID_WIDTH  = 3'd4;
  localparam logic [2:0] REG_GRID_HEIGHT = 3'd5;

  // Register reset values
  localparam logic [31:0] RST_MIN_LON     = 32'd507909243;
  localparam logic [31:0] RST_MIN_LAT     = 32'(-32'sd261905167);
  localparam logic [31:0] RST_LON_SCALE   = 32'd341151;
  localparam logic [31:0] RST_LAT_SCALE   = 32'd733832;
  localparam logic [8:0]  RST_GRID_WIDTH  = 9'd256;
  localparam logic [8:0]  RST_GRID_HEIGHT = 9'd256;

  // Op codes
  localparam logic OP_SCATTER = 1'b0;
  localparam logic OP_READ    = 1'b1;

  // Status codes
  localparam logic ST_DONE  = 1'b0;
  localparam logic ST_RANGE = 1'b1;

  // Product is Q.38: Q10.22 degrees times Q16.16 cells per degree
  localparam int          FRAC_BITS  = 38;
  // 1.5 in Q.38: negative products at or above this truncate below zero
  localparam logic [63:0] NEG_BOUND  = 64'd3 << (FRAC_BITS - 1);

endpackage

`default_nettype wire

// ===== rtl/lonlat_grid_scatter_resample_top.sv =====
// Lon/lat grid scatter resampler: nearest-cell forward mapping into a grid store.
// Six-register pipeline with a single-port read-first grid memory.
// Depends on llgsr_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake            Payload
// s_axis    in   tvalid/tready        tuser: op; tdata: lon, lat, sample_value, cell_index
// m_axis    out  tvalid/tready        tuser: status; tdata: cell_position, cell_value
// cfg       in   cfg_valid/cfg_ready  cfg_index, cfg_data (always ready)
//
// One word per cycle sustained while m_axis does not stall; the accepting edge
// loads the first of five compute stages, and the output register is loaded
// from the grid memory access after the fifth.
// The whole pipeline advances together; a stall on m_axis freezes every stage.
// After reset a clearing pass zeroes all MAX_WIDTH*MAX_HEIGHT grid cells
// (65536 by default) with s_axis_tready low; config writes are taken throughout.
// Grid memory: one address per cycle, read old data and write in the same cycle.
module lonlat_grid_scatter_resample_top #(
  parameter int MAX_WIDTH  = llgsr_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = llgsr_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [95:0] s_axis_tdata,   // lon[31:0], lat[63:32], sample_value[79:64],
                                           // cell_index[95:80]
  input  wire logic [0:0]  s_axis_tuser,   // op[0]
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // cell_position[15:0], cell_value[31:16]
  output logic [0:0]       m_axis_tuser,   // status[0]
  // configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int          CELLS  = MAX_WIDTH * MAX_HEIGHT;
  localparam int          AW     = $clog2(CELLS);
  localparam logic [24:0] CELLS_V = 25'(CELLS);
  localparam logic [12:0] MAXW_V  = 13'(MAX_WIDTH);
  localparam logic [12:0] MAXH_V  = 13'(MAX_HEIGHT);
  localparam logic [AW-1:0] LAST_ADDR = AW'(CELLS - 1);

  // Configuration registers
  logic [31:0] min_lon, min_lat, lon_scale, lat_scale;
  logic [8:0]  grid_width, grid_height;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_lon     <= llgsr_pkg::RST_MIN_LON;
      min_lat     <= llgsr_pkg::RST_MIN_LAT;
      lon_scale   <= llgsr_pkg::RST_LON_SCALE;
      lat_scale   <= llgsr_pkg::RST_LAT_SCALE;
      grid_width  <= llgsr_pkg::RST_GRID_WIDTH;
      grid_height <= llgsr_pkg::RST_GRID_HEIGHT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        llgsr_pkg::REG_MIN_LON:     min_lon     <= cfg_data;
        llgsr_pkg::REG_MIN_LAT:     min_lat     <= cfg_data;
        llgsr_pkg::REG_LON_SCALE:   lon_scale   <= cfg_data;
        llgsr_pkg::REG_LAT_SCALE:   lat_scale   <= cfg_data;
        llgsr_pkg::REG_GRID_WIDTH:  grid_width  <= cfg_data[8:0];
        llgsr_pkg::REG_GRID_HEIGHT: grid_height <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // Effective dimensions, clamped to the store size
  logic [8:0]  width_eff, height_eff;
  assign width_eff  = ({4'b0, grid_width}  > MAXW_V) ? 9'(MAX_WIDTH)  : grid_width;
  assign height_eff = ({4'b0, grid_height} > MAXH_V) ? 9'(MAX_HEIGHT) : grid_height;

  // Per-axis views: index 0 longitude/columns, 1 latitude/rows
  logic [31:0] coord[2];
  logic [31:0] origin[2];
  logic [31:0] scale[2];
  logic [8:0]  limit[2];
  assign coord[0]  = s_axis_tdata[31:0];
  assign coord[1]  = s_axis_tdata[63:32];
  assign origin[0] = min_lon;
  assign origin[1] = min_lat;
  assign scale[0]  = lon_scale;
  assign scale[1]  = lat_scale;
  assign limit[0]  = width_eff;
  assign limit[1]  = height_eff;

  // Clearing pass after reset
  logic          clearing;
  logic [AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == LAST_ADDR) clearing <= 1'b0;
    end
  end

  // Global advance: every stage moves when the output register can take a word
  logic en;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en && !clearing;

  // Pipeline registers
  logic        v1, v2, v3, v4, v5;
  logic        op1, op2, op3, op4, op5;
  logic [15:0] val1, val2, val3, val4, val5;
  logic [15:0] idx1, idx2, idx3, idx4;
  logic [32:0] d1[2];
  logic        neg2[2], neg3[2];
  logic [31:0] mag2[2];
  logic [63:0] prod3[2];
  logic        ok4[2];
  logic [8:0]  ax4[2];
  logic          scat_ok5, rd_ok5;
  logic [AW-1:0] addr5;
  logic [15:0]   pos5;

  // Stage 4 combinational: rounding and range test per axis
  logic [26:0] rnd[2];
  logic        in_lim[2];
  // Stage 5 combinational: linear cell position
  logic [17:0] lin_pos;
  logic [32:0] dneg[2];

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      dneg[a]   = 33'd0 - d1[a];
      rnd[a]    = {1'b0, prod3[a][63:llgsr_pkg::FRAC_BITS]}
                  + 27'(prod3[a][llgsr_pkg::FRAC_BITS-1]);
      in_lim[a] = neg3[a] ? (limit[a] != 9'd0) : (rnd[a] < {18'b0, limit[a]});
    end
    lin_pos = 18'(ax4[1]) * 18'(width_eff) + 18'(ax4[0]);
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      v1 <= s_axis_tvalid && s_axis_tready;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      m_axis_tvalid <= v5;
    end
  end

  // Payload through the compute stages
  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1: offset from grid origin, exact in 33 bits
      op1  <= s_axis_tuser[0];
      val1 <= s_axis_tdata[79:64];
      idx1 <= s_axis_tdata[95:80];
      for (int a = 0; a < 2; a++) begin
        d1[a] <= {coord[a][31], coord[a]} - {origin[a][31], origin[a]};
      end
      // stage 2: sign and magnitude (magnitude stays below 2^32)
      op2  <= op1;
      val2 <= val1;
      idx2 <= idx1;
      for (int a = 0; a < 2; a++) begin
        neg2[a] <= d1[a][32];
        mag2[a] <= d1[a][32] ? dneg[a][31:0] : d1[a][31:0];
      end
      // stage 3: scale product, Q.38
      op3  <= op2;
      val3 <= val2;
      idx3 <= idx2;
      for (int a = 0; a < 2; a++) begin
        neg3[a]  <= neg2[a];
        prod3[a] <= 64'(mag2[a]) * 64'(scale[a]);
      end
      // stage 4: round half up, negative side truncates to zero below 1.5
      op4  <= op3;
      val4 <= val3;
      idx4 <= idx3;
      for (int a = 0; a < 2; a++) begin
        ax4[a] <= neg3[a] ? 9'd0 : rnd[a][8:0];
        ok4[a] <= in_lim[a] && (!neg3[a] || (prod3[a] < llgsr_pkg::NEG_BOUND));
      end
      // stage 5: cell address and outcome
      op5      <= op4;
      val5     <= val4;
      scat_ok5 <= ok4[0] && ok4[1];
      rd_ok5   <= {9'b0, idx4} < CELLS_V;
      if (op4 == llgsr_pkg::OP_READ) begin
        addr5 <= AW'(idx4);
        pos5  <= idx4;
      end else begin
        addr5 <= AW'(lin_pos);
        pos5  <= (ok4[0] && ok4[1]) ? lin_pos[15:0] : 16'd0;
      end
    end
  end

  // Grid memory: scatter writes the sample, read clears the cell
  logic [15:0]   grid_mem[CELLS];
  logic [15:0]   rd_data;
  logic          mem_we;
  logic [15:0]   mem_wdata;

  assign mem_we    = v5 && ((op5 == llgsr_pkg::OP_READ) ? rd_ok5 : scat_ok5);
  assign mem_wdata = (op5 == llgsr_pkg::OP_READ) ? 16'd0 : val5;

  always_ff @(posedge clk) begin
    if (clearing) begin
      grid_mem[clr_addr] <= 16'd0;
    end else if (en) begin
      rd_data <= grid_mem[addr5];
      if (mem_we) grid_mem[addr5] <= mem_wdata;
    end
  end

  // Output register
  logic        out_status;
  logic [15:0] out_pos;
  logic        out_rd;

  always_ff @(posedge clk) begin
    if (en) begin
      out_status <= (op5 == llgsr_pkg::OP_SCATTER) && !scat_ok5;
      out_pos    <= pos5;
      out_rd     <= (op5 == llgsr_pkg::OP_READ) && rd_ok5;
    end
  end

  assign m_axis_tuser[0]     = out_status ? llgsr_pkg::ST_RANGE : llgsr_pkg::ST_DONE;
  assign m_axis_tdata[15:0]  = out_pos;
  assign m_axis_tdata[31:16] = out_rd ? rd_data : 16'd0;

  // Checks
  a_no_accept_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s_axis_tready)
    else $error("word accepted during grid clearing");

  a_pipe_empty_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !(v5 || m_axis_tvalid))
    else $error("pipeline holds a word during grid clearing");

  a_range_zero_payload: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[0] == llgsr_pkg::ST_RANGE) |-> m_axis_tdata == 32'd0)
    else $error("out-of-range scatter carries nonzero payload");

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking bench for lonlat_grid_scatter_resample_top: a directed probe list, then
// randomized phases over several grid configurations, each scored by an in-bench regrid model.
// Depends on llgsr_pkg and the top-level RTL.
`timescale 1ns / 1ps

module tb;
  import llgsr_pkg::*;

  localparam int MAX_W = MAX_WIDTH_DEF;
  localparam int MAX_H = MAX_HEIGHT_DEF;
  // clearing pass moves no word until the whole grid is zeroed; allow a wide margin
  localparam int STALL_LIMIT = 200000;

  typedef struct packed {
    logic        status;
    logic [15:0] pos;
    logic [15:0] value;
  } cell_result_t;

  typedef struct {
    logic         op;
    bit [31:0]    lon;
    bit [31:0]    lat;
    bit [15:0]    sval;
    bit [15:0]    cidx;
    bit           typed;
    cell_result_t want;
  } probe_row_t;

  typedef struct {
    bit [31:0]   lon0;
    bit [31:0]   lat0;
    bit [31:0]   lon_k;
    bit [31:0]   lat_k;
    bit [8:0]    cols;
    bit [8:0]    rows;
    int unsigned items;
  } grid_phase_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  wire logic   s_axis_tready;
  logic [95:0] s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;
  wire logic   m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  wire logic [31:0] m_axis_tdata;
  wire logic [0:0]  m_axis_tuser;
  logic        cfg_valid = 1'b0;
  wire logic   cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // register shadow, as left by reset
  bit [31:0] west_edge  = RST_MIN_LON;
  bit [31:0] south_edge = RST_MIN_LAT;
  bit [31:0] col_scale  = RST_LON_SCALE;
  bit [31:0] row_scale  = RST_LAT_SCALE;
  bit [8:0]  grid_cols  = RST_GRID_WIDTH;
  bit [8:0]  grid_rows  = RST_GRID_HEIGHT;

  bit [15:0]    grid_cells [MAX_W * MAX_H];
  bit [15:0]    placed_cells [$];
  cell_result_t cell_results_due [$];
  int unsigned  mismatches = 0;
  int unsigned  idle_cycles = 0;
  int unsigned  src_run = 0;
  int unsigned  sink_run = 0;

  lonlat_grid_scatter_resample_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Coordinate to axis index, rounded half up and truncated toward zero
  function automatic bit map_axis(bit [31:0] coord, bit [31:0] origin, bit [31:0] scale,
                                  int unsigned lim, output int unsigned idx);
    longint    d;
    bit [63:0] mag, prod, pick;
    idx = 0;
    d = longint'($signed(coord)) - longint'($signed(origin));
    mag = (d < 0) ? 64'(-d) : 64'(d);
    prod = mag * {32'd0, scale};
    if (d >= 0) begin
      pick = (prod >> FRAC_BITS) + ((prod >> (FRAC_BITS - 1)) & 64'd1);
    end else if (prod >= NEG_BOUND) begin
      return 1'b0;
    end else begin
      pick = 64'd0;
    end
    if (pick >= lim) return 1'b0;
    idx = pick[31:0];
    return 1'b1;
  endfunction

  // Expected result of one word; updates the grid shadow
  function automatic cell_result_t predict_regrid(logic op, bit [31:0] lon, bit [31:0] lat,
                                                  bit [15:0] sval, bit [15:0] cidx);
    cell_result_t res;
    int unsigned  col, row, cols_used, rows_used;
    res = '{ST_DONE, 16'd0, 16'd0};
    if (op == OP_SCATTER) begin
      cols_used = (grid_cols > MAX_W) ? MAX_W : grid_cols;
      rows_used = (grid_rows > MAX_H) ? MAX_H : grid_rows;
      if (map_axis(lon, west_edge, col_scale, cols_used, col) &&
          map_axis(lat, south_edge, row_scale, rows_used, row)) begin
        res.pos = 16'(row * cols_used + col);
        grid_cells[row * cols_used + col] = sval;
        placed_cells.push_back(res.pos);
        if (placed_cells.size() > 64) void'(placed_cells.pop_front());
      end else begin
        res.status = ST_RANGE;
      end
    end else begin
      res.pos = cidx;
      res.value = grid_cells[cidx];
      grid_cells[cidx] = 16'd0;
    end
    return res;
  endfunction

  // Coordinate that lands near a given slot on an axis, optionally jittered by +-half a cell
  function automatic bit [31:0] coord_near(bit [31:0] origin, bit [31:0] scale, longint slot,
                                           bit jitter);
    longint    pitch, off;
    bit [63:0] sum;
    pitch = (scale == 0) ? (longint'(1) << 24) : ((longint'(1) << FRAC_BITS) / longint'(scale));
    off = slot * pitch;
    if (jitter) off += longint'({$urandom, $urandom} % 64'(pitch + 1)) - pitch / 2;
    sum = 64'(longint'($signed(origin)) + off);
    return sum[31:0];
  endfunction

  // Per-word wait, with occasional runs of back-to-back words
  function automatic int unsigned draw_wait(ref int unsigned run_left);
    if (run_left > 0) begin
      run_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      run_left = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 15);
  endfunction

  function automatic void flag_result(string what, cell_result_t want, cell_result_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("tb mismatch (%s): expected status %h pos %h value %h, got status %h pos %h value %h",
               what, want.status, want.pos, want.value, got.status, got.pos, got.value);
  endfunction

  // Drive one input word at the falling edge; predict at acceptance
  task automatic send_word(logic op, bit [31:0] lon, bit [31:0] lat, bit [15:0] sval,
                           bit [15:0] cidx, bit typed, cell_result_t want);
    int unsigned  gap;
    cell_result_t res;
    gap = draw_wait(src_run);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tdata = {cidx, sval, lat, lon};
    s_axis_tuser = op;
    s_axis_tvalid = 1'b1;
    do @(posedge clk); while (s_axis_tready !== 1'b1);
    res = predict_regrid(op, lon, lat, sval, cidx);
    cell_results_due.push_back(typed ? want : res);
    @(negedge clk);
    // word taken; the next call raises valid again in this same step if it has no gap
    s_axis_tvalid = 1'b0;
  endtask

  // Result side back-pressure
  initial begin : result_sink
    int unsigned stall;
    @(negedge clk);
    forever begin
      stall = draw_wait(sink_run);
      if (stall > 0) begin
        m_axis_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_axis_tready = 1'b1;
      do @(posedge clk); while (m_axis_tvalid !== 1'b1);
      @(negedge clk);
    end
  end

  // Score each result word against the oldest prediction
  always @(posedge clk) begin : result_check
    cell_result_t got, want;
    if (!rst && m_axis_tvalid === 1'b1 && m_axis_tready) begin
      got = '{m_axis_tuser[0], m_axis_tdata[15:0], m_axis_tdata[31:16]};
      if (cell_results_due.size() == 0) begin
        flag_result("no result due", '0, got);
      end else begin
        want = cell_results_due.pop_front();
        if (got.status !== want.status || got.pos !== want.pos || got.value !== want.value)
          flag_result("field", want, got);
      end
    end
  end

  // Watchdog: cycles with no word moving on any channel
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready === 1'b1) || (m_axis_tvalid === 1'b1 && m_axis_tready) ||
        (cfg_valid && cfg_ready === 1'b1))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  initial begin : stimulus
    probe_row_t  probe_rows [$];
    grid_phase_t phases [8];
    logic [2:0]  reg_code [6];
    bit [31:0]   reg_word [6];
    bit [31:0]   w0, s0, kx, ky, lon, lat;
    bit [15:0]   sval, cidx;
    longint      lon_edge, lat_edge;
    logic        op;
    int unsigned pick, cols_used, rows_used;

    repeat (10) @(negedge clk);
    rst = 1'b0;

    // Directed probes under the reset configuration
    w0 = RST_MIN_LON;
    s0 = RST_MIN_LAT;
    kx = RST_LON_SCALE;
    ky = RST_LAT_SCALE;
    // smallest negative offset whose product reaches 1.5 cells
    lon_edge = (longint'(NEG_BOUND) + longint'(kx) - 1) / longint'(kx);
    lat_edge = (longint'(NEG_BOUND) + longint'(ky) - 1) / longint'(ky);

    // empty grid, both index extremes
    probe_rows.push_back('{OP_READ, $urandom, $urandom, 16'($urandom), 16'h0000, 1'b1,
                           '{ST_DONE, 16'h0000, 16'h0000}});
    probe_rows.push_back('{OP_READ, $urandom, $urandom, 16'($urandom), 16'hFFFF, 1'b1,
                           '{ST_DONE, 16'hFFFF, 16'h0000}});
    // sample right on the origin, then read back and read again after the clear
    probe_rows.push_back('{OP_SCATTER, w0, s0, 16'hFFFF, 16'($urandom), 1'b1,
                           '{ST_DONE, 16'h0000, 16'h0000}});
    probe_rows.push_back('{OP_READ, $urandom, $urandom, 16'($urandom), 16'h0000, 1'b1,
                           '{ST_DONE, 16'h0000, 16'hFFFF}});
    probe_rows.push_back('{OP_READ, $urandom, $urandom, 16'($urandom), 16'h0000, 1'b1,
                           '{ST_DONE, 16'h0000, 16'h0000}});
    // just west of the origin: still column 0 below 1.5 cells, out at 1.5
    probe_rows.push_back('{OP_SCATTER, 32'(longint'($signed(w0)) - lon_edge + 1), s0, 16'h0001,
                           16'($urandom), 1'b1, '{ST_DONE, 16'h0000, 16'h0000}});
    probe_rows.push_back('{OP_SCATTER, 32'(longint'($signed(w0)) - lon_edge), s0, 16'($urandom),
                           16'($urandom), 1'b1, '{ST_RANGE, 16'h0000, 16'h0000}});
    // coordinate extremes are all off the grid
    probe_rows.push_back('{OP_SCATTER, 32'h8000_0000, s0, 16'($urandom), 16'($urandom), 1'b1,
                           '{ST_RANGE, 16'h0000, 16'h0000}});
    probe_rows.push_back('{OP_SCATTER, 32'h7FFF_FFFF, s0, 16'($urandom), 16'($urandom), 1'b1,
                           '{ST_RANGE, 16'h0000, 16'h0000}});
    probe_rows.push_back('{OP_SCATTER, w0, 32'h7FFF_FFFF, 16'($urandom), 16'($urandom), 1'b1,
                           '{ST_RANGE, 16'h0000, 16'h0000}});
    probe_rows.push_back('{OP_SCATTER, w0, 32'h8000_0000, 16'($urandom), 16'($urandom), 1'b1,
                           '{ST_RANGE, 16'h0000, 16'h0000}});
    probe_rows.push_back('{OP_SCATTER, w0, 32'(longint'($signed(s0)) - lat_edge), 16'($urandom),
                           16'($urandom), 1'b1, '{ST_RANGE, 16'h0000, 16'h0000}});
    // far corner, one past each edge, an interior cell, overwrite of the corner
    probe_rows.push_back('{OP_SCATTER, coord_near(w0, kx, 255, 0), coord_near(s0, ky, 255, 0),
                           16'hA5A5, 16'($urandom), 1'b0, '0});
    probe_rows.push_back('{OP_SCATTER, coord_near(w0, kx, 256, 0), s0, 16'($urandom),
                           16'($urandom), 1'b0, '0});
    probe_rows.push_back('{OP_SCATTER, w0, coord_near(s0, ky, 256, 0), 16'($urandom),
                           16'($urandom), 1'b0, '0});
    probe_rows.push_back('{OP_SCATTER, coord_near(w0, kx, 17, 0), coord_near(s0, ky, 42, 0),
                           16'h0000, 16'($urandom), 1'b0, '0});
    probe_rows.push_back('{OP_SCATTER, coord_near(w0, kx, 255, 0), coord_near(s0, ky, 255, 0),
                           16'h5A5A, 16'($urandom), 1'b0, '0});
    probe_rows.push_back('{OP_READ, $urandom, $urandom, 16'($urandom), 16'hFFFF, 1'b0, '0});
    probe_rows.push_back('{OP_READ, $urandom, $urandom, 16'($urandom), 16'(42 * 256 + 17), 1'b0,
                           '0});
    probe_rows.push_back('{OP_READ, $urandom, $urandom, 16'($urandom), 16'h0000, 1'b0, '0});
    probe_rows.push_back('{OP_SCATTER, coord_near(w0, kx, 1, 1), coord_near(s0, ky, 1, 1),
                           16'($urandom), 16'($urandom), 1'b0, '0});
    probe_rows.push_back('{OP_READ, $urandom, $urandom, 16'($urandom), 16'h0101, 1'b0, '0});
    // one cell west and south rounds back to cell 0
    probe_rows.push_back('{OP_SCATTER, coord_near(w0, kx, -1, 0), coord_near(s0, ky, -1, 0),
                           16'($urandom), 16'($urandom), 1'b0, '0});
    probe_rows.push_back('{OP_READ, $urandom, $urandom, 16'($urandom), 16'h8000, 1'b0, '0});

    foreach (probe_rows[i])
      send_word(probe_rows[i].op, probe_rows[i].lon, probe_rows[i].lat, probe_rows[i].sval,
                probe_rows[i].cidx, probe_rows[i].typed, probe_rows[i].want);

    // Random phases: small grids, one-cell grid, zero and oversized sizes, scale extremes
    phases[0] = '{$urandom, $urandom, $urandom_range(1 << 14, 1 << 22),
                  $urandom_range(1 << 14, 1 << 22), 9'd16, 9'd8, 120};
    phases[1] = '{$urandom, $urandom, $urandom_range(1 << 12, 1 << 20),
                  $urandom_range(1 << 12, 1 << 20), 9'd1, 9'd1, 80};
    phases[2] = '{$urandom, $urandom, $urandom_range(1 << 14, 1 << 22),
                  $urandom_range(1 << 14, 1 << 22), 9'd0, 9'd511, 40};
    phases[3] = '{$urandom, $urandom, 32'd0, 32'hFFFF_FFFF, 9'd511, 9'd256, 120};
    phases[4] = '{32'h8000_0000, 32'h7FFF_FFFF, $urandom_range(1 << 16, 1 << 24),
                  $urandom_range(1 << 16, 1 << 24), 9'd256, 9'd256, 100};
    phases[5] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'd0, 9'd200, 9'd3, 100};
    phases[6] = '{$urandom, $urandom, $urandom, $urandom_range(1 << 10, 1 << 26),
                  9'd300, 9'd0, 60};
    phases[7] = '{$urandom, $urandom, $urandom_range(1 << 12, 1 << 24),
                  $urandom_range(1 << 12, 1 << 24), 9'($urandom_range(1, 256)),
                  9'($urandom_range(1, 256)), 120};

    reg_code = '{REG_MIN_LON, REG_MIN_LAT, REG_LON_SCALE, REG_LAT_SCALE,
                 REG_GRID_WIDTH, REG_GRID_HEIGHT};

    foreach (phases[p]) begin
      // config only while nothing is in flight
      while (cell_results_due.size() != 0) @(negedge clk);
      // size registers carry random upper bits, which the block ignores
      reg_word = '{phases[p].lon0, phases[p].lat0, phases[p].lon_k, phases[p].lat_k,
                   ($urandom & ~32'h1FF) | phases[p].cols, ($urandom & ~32'h1FF) | phases[p].rows};
      for (int k = 0; k < 6; k++) begin
        cfg_index = reg_code[k];
        cfg_data = reg_word[k];
        cfg_valid = 1'b1;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        case (reg_code[k])
          REG_MIN_LON:     west_edge = cfg_data;
          REG_MIN_LAT:     south_edge = cfg_data;
          REG_LON_SCALE:   col_scale = cfg_data;
          REG_LAT_SCALE:   row_scale = cfg_data;
          REG_GRID_WIDTH:  grid_cols = cfg_data[8:0];
          REG_GRID_HEIGHT: grid_rows = cfg_data[8:0];
          default: ;
        endcase
        @(negedge clk);
      end
      cfg_valid = 1'b0;

      cols_used = (grid_cols > MAX_W) ? MAX_W : grid_cols;
      rows_used = (grid_rows > MAX_H) ? MAX_H : grid_rows;
      for (int n = 0; n < phases[p].items; n++) begin
        lon = $urandom;
        lat = $urandom;
        sval = 16'($urandom);
        cidx = 16'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          // aimed at the grid, a couple of cells of margin on each side
          op = OP_SCATTER;
          lon = coord_near(west_edge, col_scale,
                           longint'($urandom_range(0, cols_used + 3)) - 2, 1);
          lat = coord_near(south_edge, row_scale,
                           longint'($urandom_range(0, rows_used + 3)) - 2, 1);
        end else if (pick < 72) begin
          op = OP_SCATTER;
        end else if (pick < 90 && placed_cells.size() > 0) begin
          op = OP_READ;
          cidx = placed_cells[$urandom_range(0, placed_cells.size() - 1)];
        end else begin
          op = OP_READ;
        end
        send_word(op, lon, lat, sval, cidx, 1'b0, '0);
      end
    end
    s_axis_tvalid = 1'b0;

    // drain, then leave room for any stray result
    while (cell_results_due.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (mismatches == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/llgsr_pkg.sv
rtl/lonlat_grid_scatter_resample_top.sv
sim/tb.sv
